// ===== hw/rtl/sha256_pkg.sv =====
// shared types, constants and round functions of the sha-256 stream hasher
package sha256_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFinal,
    StEmit
  } sha_state_e;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds   = 64;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned HashWords   = 8;
  localparam int unsigned LenWidth    = 61;
  localparam int unsigned FillWidth   = 6;
  localparam int unsigned RoundWidth  = 6;

  localparam logic [7:0]           PadByte    = 8'h80;
  localparam logic [FillWidth-1:0] LenOffset  = 6'd56;
  localparam logic [FillWidth-1:0] LastByte   = 6'd63;
  localparam logic [RoundWidth-1:0] LastRound = 6'd63;

  // initial hash values
  localparam word_t InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // compression sigma on the a word
  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // compression sigma on the e word
  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // schedule sigma on w[i-15]
  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // schedule sigma on w[i-2]
  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha256_if.sv =====
// request and digest channel interfaces of the sha-256 stream hasher
interface sha256_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha256_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [63:0] digest_word2;
  logic [63:0] digest_word3;
  logic        length_error;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3,
                  output length_error, input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3,
                  input length_error, output ready);
endinterface

// ===== hw/rtl/sha256_stream_hasher.sv =====
// sha-256 stream hasher: byte packing, padding and one shared round unit
//
// req_i takes one request per accepted handshake: a message byte with a
// present flag and an end-of-message flag. res_o carries one digest per
// message as four big-endian 64-bit words plus a length error flag.
// A byte that does not fill the block is packed into it and req_i stays
// ready. The 64th byte of a block starts the compression: 64 rounds in
// the single round unit, one after another, then an add into the hash
// words. An end request inserts the padding one byte per cycle between
// compressions (9 to 72 bytes), which runs one or two more compressions;
// the digest is then loaded into the output register once that is free.
// req_i is ready only while idle. A message longer than 2^61-1
// bytes ends with the error flag and a zero digest, without padding.
// The output register lets the next message proceed while a digest waits;
// only a second digest waits until res_o takes the first.
// Reset (rst_ni low, asynchronous) loads the initial hash values, clears
// the length and fill counters and drops res_o.valid.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sha256_req_if.sink          req_i,
  sha256_res_if.source        res_o
);

  sha_state_e            state_q, state_d;
  logic [FillWidth-1:0]  fill_q, fill_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [RoundWidth-1:0] cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  end_q, end_d;
  logic                  first_q, first_d;
  logic                  lenph_q, lenph_d;
  logic                  err_q, err_d;
  word_t                 h_q [HashWords];
  word_t                 h_d [HashWords];
  word_t                 s_q [HashWords];
  word_t                 s_d [HashWords];
  word_t                 blk_q [BlockWords];
  word_t                 blk_d [BlockWords];
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           dig_q [4];
  logic [63:0]           dig_d [4];
  logic                  out_err_q, out_err_d;

  logic                  absorb_en;
  logic [7:0]            absorb_byte;
  logic                  ovf_next;
  logic [63:0]           bit_len;
  logic [1:0]            lane;
  word_t                 t1, t2, new_w;

  // round unit and schedule extension
  assign t1 = s_q[7] + big_sigma1(s_q[4]) + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]))
            + RoundK[cnt_q] + blk_q[0];
  assign t2 = big_sigma0(s_q[0])
            + ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
  assign new_w = blk_q[0] + small_sigma0(blk_q[1]) + blk_q[9] + small_sigma1(blk_q[14]);

  assign bit_len = {len_q, 3'b000};
  assign lane    = 2'd3 - fill_q[1:0];

  // output channel
  assign res_o.valid        = out_valid_q;
  assign res_o.digest_word0 = dig_q[0];
  assign res_o.digest_word1 = dig_q[1];
  assign res_o.digest_word2 = dig_q[2];
  assign res_o.digest_word3 = dig_q[3];
  assign res_o.length_error = out_err_q;

  // sequencer, next state and datapath
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    end_d       = end_q;
    first_d     = first_q;
    lenph_d     = lenph_q;
    err_d       = err_q;
    h_d         = h_q;
    s_d         = s_q;
    blk_d       = blk_q;
    dig_d       = dig_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !res_o.ready;
    absorb_en   = 1'b0;
    absorb_byte = req_i.data_byte;
    ovf_next    = ovf_q;
    req_i.ready = 1'b0;

    case (state_q)
      StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.byte_present && !ovf_q) begin
            if (&len_q) begin
              ovf_d    = 1'b1;
              ovf_next = 1'b1;
            end else begin
              len_d     = len_q + 1'b1;
              absorb_en = 1'b1;
            end
          end
          if (req_i.end_of_message) begin
            if (ovf_next) begin
              err_d   = 1'b1;
              state_d = StEmit;
            end else begin
              end_d   = 1'b1;
              first_d = 1'b1;
              state_d = StPad;
            end
          end
        end
      end
      StPad: begin
        absorb_en = 1'b1;
        first_d   = 1'b0;
        if (first_q) begin
          absorb_byte = PadByte;
        end else if (lenph_q || fill_q == LenOffset) begin
          lenph_d     = 1'b1;
          absorb_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
        end else begin
          absorb_byte = 8'h00;
        end
      end
      StRound: begin
        s_d[7] = s_q[6];
        s_d[6] = s_q[5];
        s_d[5] = s_q[4];
        s_d[4] = s_q[3] + t1;
        s_d[3] = s_q[2];
        s_d[2] = s_q[1];
        s_d[1] = s_q[0];
        s_d[0] = t1 + t2;
        for (int i = 0; i < BlockWords - 1; i++) begin
          blk_d[i] = blk_q[i+1];
        end
        blk_d[BlockWords-1] = new_w;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastRound) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        for (int i = 0; i < HashWords; i++) begin
          h_d[i] = h_q[i] + s_q[i];
        end
        if (lenph_q) begin
          state_d = StEmit;
        end else if (end_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (!out_valid_q || res_o.ready) begin
          for (int i = 0; i < 4; i++) begin
            dig_d[i] = err_q ? 64'd0 : {h_q[2*i], h_q[2*i+1]};
          end
          out_err_d   = err_q;
          out_valid_d = 1'b1;
          h_d         = InitHash;
          len_d       = '0;
          fill_d      = '0;
          ovf_d       = 1'b0;
          end_d       = 1'b0;
          first_d     = 1'b0;
          lenph_d     = 1'b0;
          err_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // byte packing, a full block starts the rounds
    if (absorb_en) begin
      blk_d[fill_q[5:2]][{lane, 3'b000} +: 8] = absorb_byte;
      fill_d = fill_q + 1'b1;
      if (fill_q == LastByte) begin
        state_d = StRound;
        cnt_d   = '0;
        s_d     = h_q;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      end_q       <= 1'b0;
      first_q     <= 1'b0;
      lenph_q     <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= InitHash;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      end_q       <= end_d;
      first_q     <= first_d;
      lenph_q     <= lenph_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
    end
  end

  // working words, block window and result payload
  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    blk_q     <= blk_d;
    dig_q     <= dig_d;
    out_err_q <= out_err_d;
  end

endmodule

// ===== tb/sv/sha256_stream_hasher_test.sv =====
// self-checking testbench of the sha-256 stream hasher with a digest predictor
`timescale 1ns / 100ps

module sha256_stream_hasher_test
  import sha256_pkg::*;
();

  typedef struct packed {
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic        length_error;
  } digest_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       golden_known;
    digest_t    golden;
  } stim_row_t;

  localparam int unsigned RandomItems = 900;
  localparam int unsigned MinMessages = 40;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned NumDirected = 16;

  localparam digest_t NoDigest = '0;
  // well-known digests of the empty message and of "abc"
  localparam digest_t EmptyDigest = '{word0: 64'he3b0c44298fc1c14, word1: 64'h9afbf4c8996fb924,
                                      word2: 64'h27ae41e4649b934c, word3: 64'ha495991b7852b855,
                                      length_error: 1'b0};
  localparam digest_t AbcDigest = '{word0: 64'hba7816bf8f01cfea, word1: 64'h414140de5dae2223,
                                    word2: 64'hb00361a396177a9c, word3: 64'hb410ff61f20015ad,
                                    length_error: 1'b0};

  // directed requests: data, present, last, golden known, golden digest
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message
    '{8'ha5, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message, stray data ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // end flag on the last byte
    '{8'h5a, 1'b0, 1'b0, 1'b0, NoDigest},     // no byte, no end while idle
    '{8'hff, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h3c, 1'b0, 1'b0, 1'b0, NoDigest},     // no byte, no end mid message
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoDigest},     // separate empty end after bytes
    '{8'hff, 1'b1, 1'b1, 1'b0, NoDigest},     // one-byte messages at the extremes
    '{8'h00, 1'b1, 1'b1, 1'b0, NoDigest},
    '{8'h80, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h7f, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h01, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'hfe, 1'b1, 1'b1, 1'b0, NoDigest}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sha256_req_if req_if ();
  sha256_res_if res_if ();

  sha256_stream_hasher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state of the hasher
  word_t                hash_state [HashWords];
  word_t                block_buf [BlockWords];
  logic [LenWidth-1:0]  msg_len;
  int unsigned          fill_cnt;
  bit                   overflowed;

  digest_t     expected_digests [$];
  int unsigned items_sent;
  int unsigned messages_sent;
  int unsigned mismatches;
  int unsigned stuck_cycles;
  bit          calm;

  function automatic word_t ror32(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the current block, then add into the hash words
  function automatic void compress_block();
    word_t sched [NumRounds];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + sched[i-7]
               + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
    {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
    {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[i] + sched[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    hash_state[5] += f;
    hash_state[6] += g;
    hash_state[7] += h;
  endfunction

  // big-endian byte packing, compress on a full block
  function automatic void absorb_byte(logic [7:0] b);
    int unsigned idx, sh;
    idx = fill_cnt / 4;
    sh  = (3 - fill_cnt % 4) * 8;
    block_buf[idx] = (block_buf[idx] & ~(word_t'(8'hff) << sh)) | (word_t'(b) << sh);
    fill_cnt++;
    if (fill_cnt == 64) begin
      compress_block();
      fill_cnt = 0;
    end
  endfunction

  function automatic void clear_hasher_state();
    for (int i = 0; i < HashWords; i++) hash_state[i] = InitHash[i];
    for (int i = 0; i < BlockWords; i++) block_buf[i] = '0;
    msg_len    = '0;
    fill_cnt   = 0;
    overflowed = 1'b0;
  endfunction

  // one request into the predictor; returns 1 when it ends a message
  function automatic bit predict_digest(input logic [7:0] b, input bit present, input bit last,
                                        output digest_t d);
    logic [63:0] bit_len;
    d = NoDigest;
    if (present && !overflowed) begin
      if (msg_len == '1) overflowed = 1'b1;
      else begin
        msg_len++;
        absorb_byte(b);
      end
    end
    if (!last) return 1'b0;
    if (overflowed) d.length_error = 1'b1;
    else begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(PadByte);
      while (fill_cnt != LenOffset) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
      d.word0 = {hash_state[0], hash_state[1]};
      d.word1 = {hash_state[2], hash_state[3]};
      d.word2 = {hash_state[4], hash_state[5]};
      d.word3 = {hash_state[6], hash_state[7]};
    end
    clear_hasher_state();
    return 1'b1;
  endfunction

  // mostly no gap, some short, a few long; none in calm phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly short messages, some around the padding and block boundaries
  function automatic int unsigned pick_msg_len();
    int unsigned r;
    int unsigned boundary [10];
    boundary = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    r = $urandom_range(0, 99);
    if (r < 72) return $urandom_range(0, 8);
    if (r < 87) return boundary[$urandom_range(0, 9)];
    if (r < 97) return $urandom_range(9, 70);
    return $urandom_range(100, 200);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  // drive one request and record its expected digest once accepted
  task automatic send_request(input stim_row_t row);
    int unsigned gap;
    digest_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.data_byte      <= row.data;
    req_if.byte_present   <= row.present;
    req_if.end_of_message <= row.last;
    do @(posedge clk_i); while (!req_if.ready);
    if (predict_digest(row.data, row.present, row.last, predicted)) begin
      expected_digests.insert(expected_digests.size(),
                              row.golden_known ? row.golden : predicted);
      messages_sent++;
    end
    if (row.present || row.last) items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] data, input bit present, input bit last);
    stim_row_t row;
    row = '{data, present, last, 1'b0, NoDigest};
    send_request(row);
  endtask

  // stimulus
  initial begin
    int unsigned msg_bytes;
    bit          end_on_byte;
    clear_hasher_state();
    items_sent    = 0;
    messages_sent = 0;
    calm          = 1'b0;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.data_byte      <= 8'h00;
    req_if.byte_present   <= 1'b0;
    req_if.end_of_message <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) send_request(DirectedRows[i]);

    // random messages with stray idle requests in between
    while (items_sent < RandomItems + NumDirected || messages_sent < MinMessages) begin
      calm        = ($urandom_range(0, 4) == 0);
      msg_bytes   = pick_msg_len();
      end_on_byte = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < msg_bytes; k++) begin
        if ($urandom_range(0, 19) == 0) send_plain(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_plain(8'($urandom_range(0, 255)), 1'b1,
                   end_on_byte && (k == msg_bytes - 1));
      end
      if (msg_bytes == 0 || !end_on_byte) send_plain(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;

    while (expected_digests.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // digest receiver with random stalls
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare each accepted digest with the oldest expectation
  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_digests.size() == 0) begin
        report_mismatch("digest with no message pending", res_if.digest_word0, '0);
      end else begin
        want = expected_digests.pop_front();
        if (res_if.digest_word0 !== want.word0)
          report_mismatch("digest_word0", res_if.digest_word0, want.word0);
        if (res_if.digest_word1 !== want.word1)
          report_mismatch("digest_word1", res_if.digest_word1, want.word1);
        if (res_if.digest_word2 !== want.word2)
          report_mismatch("digest_word2", res_if.digest_word2, want.word2);
        if (res_if.digest_word3 !== want.word3)
          report_mismatch("digest_word3", res_if.digest_word3, want.word3);
        if (res_if.length_error !== want.length_error)
          report_mismatch("length_error", 64'(res_if.length_error), 64'(want.length_error));
      end
    end
  end

  // watchdog on cycles without any accepted request or digest
  initial mismatches = 0;
  initial stuck_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
